@@ rtl/memory_extent_table_core_assert.svh @@
// -----------------------------------------------------------------------------
// memory_extent_table_core assertion macros
// Shared property wrappers, sampled on clk and disabled while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef MEMORY_EXTENT_TABLE_CORE_ASSERT_SVH
`define MEMORY_EXTENT_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define MXT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MXT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/mxt_pkg.sv @@
// -----------------------------------------------------------------------------
// mxt_pkg
// Constants, codes and controller/datapath interface types of the extent table.
// -----------------------------------------------------------------------------
package mxt_pkg;

	localparam int MAX_EXTENTS = 32;
	localparam int IDX_W       = $clog2(MAX_EXTENTS);
	localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
	localparam int ADDR_W      = IDX_W + 1;

	localparam logic [2:0] KIND_APPEND   = 3'd0;
	localparam logic [2:0] KIND_REMOVE   = 3'd1;
	localparam logic [2:0] KIND_FIND     = 3'd2;
	localparam logic [2:0] KIND_SORT     = 3'd3;
	localparam logic [2:0] KIND_COALESCE = 3'd4;
	localparam logic [2:0] KIND_READ     = 3'd5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_FIT  = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_NOT_IN  = 3'd3;
	localparam logic [2:0] ST_OVERLAP = 3'd4;

	typedef enum logic [2:0] {
		WS_OP,
		WS_COPY,
		WS_LEFT,
		WS_RIGHT,
		WS_ACC
	} wsel_t;

	typedef struct packed {
		logic              load_op;
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		wsel_t             wr_sel;
		logic              set_st;
		logic [2:0]        st_val;
		logic              no_hit;
		logic              cut_chk;
		logic              find_a;
		logic              find_b;
		logic              rd_cap;
		logic              acc_load;
		logic              acc_eval;
		logic              acc_merge;
		logic              out_load;
		logic [CNT_W-1:0]  count;
	} ctl_t;

	typedef struct packed {
		logic hit;
		logic gt_end;
		logic left;
		logic right;
		logic fit;
		logic lt;
		logic eq;
		logic adj;
	} sts_t;

endpackage

@@ rtl/mxt_datapath.sv @@
// -----------------------------------------------------------------------------
// mxt_datapath
// Two-bank extent memory, operand and accumulator registers, result registers.
// -----------------------------------------------------------------------------
module mxt_datapath import mxt_pkg::*; (
	input  logic              clk,
	input  ctl_t              ctl,
	input  logic [31:0]       start_address,
	input  logic [31:0]       length,
	input  logic [31:0]       alignment,
	input  logic              require_inside,
	output sts_t              sts,
	output logic [2:0]        status,
	output logic [31:0]       found_address,
	output logic [31:0]       entry_address,
	output logic [31:0]       entry_size,
	output logic [CNT_W-1:0]  entry_count
);

	logic [63:0] mem_q [2*MAX_EXTENTS];
	logic [63:0] rda_q, rdb_q;
	logic [63:0] wr_data;

	logic [31:0] op_len_q, align_q;
	logic [31:0] cut_start_q, cut_end_q;
	logic        must_q;
	logic [31:0] aa_q, e_q;
	logic [31:0] acc_a_q, acc_s_q, acc_ns_q;
	logic [2:0]  st_q;
	logic [31:0] found_q, ea_q, es_q;
	logic [31:0] op_start_q;

	logic [31:0] s_a, l_a, re_a, s_b, fit_end, aa_next;

	assign s_a     = rda_q[63:32];
	assign l_a     = rda_q[31:0];
	assign re_a    = s_a + l_a;
	assign s_b     = rdb_q[63:32];
	assign fit_end = aa_q + op_len_q;
	assign aa_next = (s_a + align_q - 32'd1) & (32'd0 - align_q);

	always_comb begin
		sts.hit    = (cut_end_q > s_a) && (cut_start_q < re_a);
		sts.gt_end = cut_end_q > s_a;
		sts.left   = cut_start_q > s_a;
		sts.right  = cut_end_q < re_a;
		sts.fit    = fit_end <= e_q;
		sts.lt     = s_b < s_a;
		sts.eq     = s_b == s_a;
		sts.adj    = (s_a - acc_a_q) <= acc_s_q;
	end

	always_comb begin
		case (ctl.wr_sel)
			WS_OP:    wr_data = {op_start_q, op_len_q};
			WS_COPY:  wr_data = rda_q;
			WS_LEFT:  wr_data = {s_a, cut_start_q - s_a};
			WS_RIGHT: wr_data = {cut_end_q, re_a - cut_end_q};
			WS_ACC:   wr_data = {acc_a_q, acc_s_q};
			default:  wr_data = rda_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.wr_addr] <= wr_data;
		end
		rda_q <= mem_q[ctl.a_addr];
		rdb_q <= mem_q[ctl.b_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.load_op) begin
			op_start_q  <= start_address;
			op_len_q    <= length;
			align_q     <= alignment;
			cut_start_q <= start_address;
			cut_end_q   <= start_address + length;
			must_q      <= require_inside;
			st_q        <= ST_OK;
			found_q     <= '0;
			ea_q        <= '0;
			es_q        <= '0;
		end
		if (ctl.find_a) begin
			aa_q <= aa_next;
			e_q  <= re_a;
		end
		if (ctl.find_b && sts.fit) begin
			found_q     <= aa_q;
			cut_start_q <= aa_q;
			cut_end_q   <= fit_end;
			must_q      <= 1'b1;
		end
		if (ctl.no_hit) begin
			st_q <= must_q ? ST_NOT_IN : ST_OK;
		end
		if (ctl.cut_chk && must_q && (cut_start_q < s_a || cut_end_q > re_a)) begin
			st_q   <= ST_OVERLAP;
			must_q <= 1'b0;
		end
		if (ctl.set_st) begin
			st_q <= ctl.st_val;
		end
		if (ctl.rd_cap) begin
			ea_q <= s_a;
			es_q <= l_a;
		end
		if (ctl.acc_load) begin
			acc_a_q <= s_a;
			acc_s_q <= l_a;
		end
		if (ctl.acc_eval) begin
			acc_ns_q <= re_a - acc_a_q;
		end
		if (ctl.acc_merge && acc_ns_q > acc_s_q) begin
			acc_s_q <= acc_ns_q;
		end
		if (ctl.out_load) begin
			status        <= st_q;
			found_address <= found_q;
			entry_address <= ea_q;
			entry_size    <= es_q;
			entry_count   <= ctl.count;
		end
	end

endmodule

@@ rtl/mxt_ctrl.sv @@
// -----------------------------------------------------------------------------
// mxt_ctrl
// Operation sequencer: bank select, entry count, scan counters, handshakes.
// -----------------------------------------------------------------------------
module mxt_ctrl import mxt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       kind,
	input  logic [4:0]       entry_index,
	output logic             out_valid,
	input  logic             out_ready,
	input  sts_t             sts,
	output ctl_t             ctl
);

	typedef enum logic [4:0] {
		S_IDLE, S_APPEND, S_READ, S_READ2,
		S_HIT_RD, S_HIT_EX, S_CUT_RD, S_CUT_EX, S_CUT_SPLIT,
		S_FIND_RD, S_FIND_A, S_FIND_B,
		S_SORT_I, S_SORT_JRD, S_SORT_JEX,
		S_CO_RD, S_CO_EX, S_CO_MG, S_CO_END,
		S_FIN
	} state_t;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_EXTENTS);
	localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

	state_t           state_q;
	logic             bank_q, stop_q, accv_q, out_valid_q;
	logic [CNT_W-1:0] n_q, i_q, j_q, d_q, ncur_q, h_q;
	logic [4:0]       idx_q;
	logic             active, slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign active    = (i_q >= h_q) && !stop_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		ctl         = '0;
		ctl.wr_sel  = WS_COPY;
		ctl.a_addr  = {bank_q, i_q[IDX_W-1:0]};
		ctl.b_addr  = {bank_q, j_q[IDX_W-1:0]};
		ctl.wr_addr = {~bank_q, d_q[IDX_W-1:0]};
		ctl.count   = n_q;
		case (state_q)
			S_IDLE: ctl.load_op = in_valid;
			S_APPEND: begin
				if (n_q >= MAX_CNT) begin
					ctl.set_st = 1'b1;
					ctl.st_val = ST_FULL;
				end else begin
					ctl.wr_en   = 1'b1;
					ctl.wr_sel  = WS_OP;
					ctl.wr_addr = {bank_q, n_q[IDX_W-1:0]};
				end
			end
			S_READ: ctl.a_addr = {bank_q, idx_q[IDX_W-1:0]};
			S_READ2: begin
				ctl.a_addr = {bank_q, idx_q[IDX_W-1:0]};
				if (CNT_W'(idx_q) < n_q) begin
					ctl.rd_cap = 1'b1;
				end else begin
					ctl.set_st = 1'b1;
					ctl.st_val = ST_NOT_IN;
				end
			end
			S_HIT_RD: ctl.no_hit = (i_q >= n_q);
			S_CUT_EX: begin
				ctl.wr_en = 1'b1;
				if (active && sts.gt_end) begin
					ctl.cut_chk = 1'b1;
					if (sts.left) begin
						ctl.wr_sel = WS_LEFT;
						if (sts.right && ncur_q >= MAX_CNT) begin
							ctl.set_st = 1'b1;
							ctl.st_val = ST_FULL;
						end
					end else if (sts.right) begin
						ctl.wr_sel = WS_RIGHT;
					end else begin
						ctl.wr_en = 1'b0;
					end
				end
			end
			S_CUT_SPLIT: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WS_RIGHT;
			end
			S_FIND_RD: begin
				if (i_q >= n_q) begin
					ctl.set_st = 1'b1;
					ctl.st_val = ST_NO_FIT;
				end
			end
			S_FIND_A: ctl.find_a = 1'b1;
			S_FIND_B: ctl.find_b = 1'b1;
			S_SORT_JRD: ctl.wr_en = (j_q >= n_q);
			S_CO_EX: begin
				if (!accv_q) begin
					ctl.acc_load = 1'b1;
				end else if (sts.adj) begin
					ctl.acc_eval = 1'b1;
				end else begin
					ctl.wr_en    = 1'b1;
					ctl.wr_sel   = WS_ACC;
					ctl.acc_load = 1'b1;
				end
			end
			S_CO_MG: ctl.acc_merge = 1'b1;
			S_CO_END: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WS_ACC;
			end
			S_FIN: ctl.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bank_q      <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			d_q         <= '0;
			ncur_q      <= '0;
			h_q         <= '0;
			stop_q      <= 1'b0;
			accv_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					i_q <= '0;
					d_q <= '0;
					if (in_valid) begin
						case (kind)
							KIND_APPEND:   state_q <= S_APPEND;
							KIND_REMOVE:   state_q <= S_HIT_RD;
							KIND_FIND:     state_q <= S_FIND_RD;
							KIND_SORT:     state_q <= S_SORT_I;
							KIND_COALESCE: begin
								accv_q  <= 1'b0;
								state_q <= S_CO_RD;
							end
							KIND_READ: begin
								idx_q   <= entry_index;
								state_q <= S_READ;
							end
							default:       state_q <= S_FIN;
						endcase
					end
				end
				S_APPEND: begin
					if (n_q < MAX_CNT) begin
						n_q <= n_q + ONE;
					end
					state_q <= S_FIN;
				end
				S_READ:  state_q <= S_READ2;
				S_READ2: state_q <= S_FIN;
				S_HIT_RD: state_q <= (i_q >= n_q) ? S_FIN : S_HIT_EX;
				S_HIT_EX: begin
					if (sts.hit) begin
						h_q     <= i_q;
						i_q     <= '0;
						d_q     <= '0;
						ncur_q  <= n_q;
						stop_q  <= 1'b0;
						state_q <= S_CUT_RD;
					end else begin
						i_q     <= i_q + ONE;
						state_q <= S_HIT_RD;
					end
				end
				S_CUT_RD: begin
					if (i_q >= n_q) begin
						bank_q  <= ~bank_q;
						n_q     <= d_q;
						state_q <= S_FIN;
					end else begin
						state_q <= S_CUT_EX;
					end
				end
				S_CUT_EX: begin
					if (active && sts.gt_end) begin
						if (sts.left) begin
							d_q <= d_q + ONE;
							if (sts.right) begin
								state_q <= (ncur_q >= MAX_CNT) ? S_FIN : S_CUT_SPLIT;
							end else begin
								i_q     <= i_q + ONE;
								state_q <= S_CUT_RD;
							end
						end else if (sts.right) begin
							d_q     <= d_q + ONE;
							i_q     <= i_q + ONE;
							state_q <= S_CUT_RD;
						end else begin
							ncur_q  <= ncur_q - ONE;
							i_q     <= i_q + ONE;
							state_q <= S_CUT_RD;
						end
					end else begin
						if (active) begin
							stop_q <= 1'b1;
						end
						d_q     <= d_q + ONE;
						i_q     <= i_q + ONE;
						state_q <= S_CUT_RD;
					end
				end
				S_CUT_SPLIT: begin
					d_q     <= d_q + ONE;
					ncur_q  <= ncur_q + ONE;
					stop_q  <= 1'b1;
					i_q     <= i_q + ONE;
					state_q <= S_CUT_RD;
				end
				S_FIND_RD: state_q <= (i_q >= n_q) ? S_FIN : S_FIND_A;
				S_FIND_A:  state_q <= S_FIND_B;
				S_FIND_B: begin
					if (sts.fit) begin
						i_q     <= '0;
						state_q <= S_HIT_RD;
					end else begin
						i_q     <= i_q + ONE;
						state_q <= S_FIND_RD;
					end
				end
				S_SORT_I: begin
					if (i_q >= n_q) begin
						bank_q  <= ~bank_q;
						state_q <= S_FIN;
					end else begin
						j_q     <= '0;
						d_q     <= '0;
						state_q <= S_SORT_JRD;
					end
				end
				S_SORT_JRD: begin
					if (j_q >= n_q) begin
						i_q     <= i_q + ONE;
						state_q <= S_SORT_I;
					end else begin
						state_q <= S_SORT_JEX;
					end
				end
				S_SORT_JEX: begin
					if (sts.lt || (sts.eq && j_q < i_q)) begin
						d_q <= d_q + ONE;
					end
					j_q     <= j_q + ONE;
					state_q <= S_SORT_JRD;
				end
				S_CO_RD: begin
					if (i_q >= n_q) begin
						if (accv_q) begin
							state_q <= S_CO_END;
						end else begin
							bank_q  <= ~bank_q;
							n_q     <= d_q;
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_CO_EX;
					end
				end
				S_CO_EX: begin
					if (!accv_q) begin
						accv_q  <= 1'b1;
						i_q     <= i_q + ONE;
						state_q <= S_CO_RD;
					end else if (sts.adj) begin
						state_q <= S_CO_MG;
					end else begin
						d_q     <= d_q + ONE;
						i_q     <= i_q + ONE;
						state_q <= S_CO_RD;
					end
				end
				S_CO_MG: begin
					i_q     <= i_q + ONE;
					state_q <= S_CO_RD;
				end
				S_CO_END: begin
					bank_q  <= ~bank_q;
					n_q     <= d_q + ONE;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/memory_extent_table_core.sv @@
// -----------------------------------------------------------------------------
// memory_extent_table_core
// Free extent table: append, remove, aligned first-fit find, sort, coalesce, read.
// -----------------------------------------------------------------------------
//  channel | handshake            | fields
//  in      | in_valid / in_ready  | kind start_address length alignment require_inside
//          |                      | entry_index
//  out     | out_valid / out_ready| status found_address entry_address entry_size
//          |                      | entry_count
//
//  One request at a time; n is the entry count. Remove scans the entries for
//  the first hit and then rewrites them into the other bank; find tries the
//  entries in order, then removes the range that fits; coalesce passes over
//  all n entries and sort compares each entry with all n. The table memory
//  has a single write port. A finished result waits in the output register
//  while the next request runs. Reset empties the table; no clearing pass.
// -----------------------------------------------------------------------------
module memory_extent_table_core import mxt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       kind,
	input  logic [31:0]      start_address,
	input  logic [31:0]      length,
	input  logic [31:0]      alignment,
	input  logic             require_inside,
	input  logic [4:0]       entry_index,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [31:0]      found_address,
	output logic [31:0]      entry_address,
	output logic [31:0]      entry_size,
	output logic [CNT_W-1:0] entry_count
);

	ctl_t ctl;
	sts_t sts;

	mxt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.entry_index (entry_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sts         (sts),
		.ctl         (ctl)
	);

	mxt_datapath u_dp (
		.clk            (clk),
		.ctl            (ctl),
		.start_address  (start_address),
		.length         (length),
		.alignment      (alignment),
		.require_inside (require_inside),
		.sts            (sts),
		.status         (status),
		.found_address  (found_address),
		.entry_address  (entry_address),
		.entry_size     (entry_size),
		.entry_count    (entry_count)
	);

endmodule

@@ rtl/mxt_checker.sv @@
// -----------------------------------------------------------------------------
// mxt_checker
// Port-level checks on the extent table core, bound to the top level.
// -----------------------------------------------------------------------------
`include "memory_extent_table_core_assert.svh"

module mxt_checker import mxt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [2:0]       status,
	input logic [31:0]      found_address,
	input logic [CNT_W-1:0] entry_count
);

	`MXT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
	`MXT_ASSERT_IMPL(a_count_max, out_valid, entry_count <= CNT_W'(MAX_EXTENTS))
	`MXT_ASSERT_IMPL(a_status_code, out_valid, status <= ST_OVERLAP)
	`MXT_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	`MXT_ASSERT_IMPL(a_found_nofit, out_valid && status == ST_NO_FIT, found_address == 32'd0)

endmodule

bind memory_extent_table_core mxt_checker u_mxt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.found_address (found_address),
	.entry_count   (entry_count)
);
